>>> rtl/tcsh_pkg.sv
// Shared types and constants for the touch channel smoother.
`default_nettype none

package tcsh_pkg;

  localparam int DATA_W   = 16;
  localparam int CH_W     = 3;
  localparam int MASK_W   = 8;
  localparam int IDX_W    = 2;

  localparam int CHANNELS_DEF     = 8;
  localparam int SMOOTH_SHIFT_DEF = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [IDX_W-1:0] REG_ENABLE_MASK    = 2'd2;

  localparam logic [DATA_W-1:0] LOW_THRESHOLD_RST  = 16'h0000;
  localparam logic [DATA_W-1:0] HIGH_THRESHOLD_RST = 16'hFFFF;
  localparam logic [MASK_W-1:0] ENABLE_MASK_RST    = 8'hFF;

  typedef struct packed {
    logic [DATA_W-1:0] low_threshold;
    logic [DATA_W-1:0] high_threshold;
    logic [MASK_W-1:0] enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel_out;
    logic              touched;
    logic [DATA_W-1:0] smoothed_value;
    logic              value_valid;
    logic [MASK_W-1:0] touched_mask;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tcsh_cfg_regs.sv
// Configuration registers: thresholds and channel enable mask.
`default_nettype none

module tcsh_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [tcsh_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [tcsh_pkg::DATA_W-1:0] wr_data,
  output tcsh_pkg::cfg_t                  cfg
);
  import tcsh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= LOW_THRESHOLD_RST;
      cfg.high_threshold <= HIGH_THRESHOLD_RST;
      cfg.enable_mask    <= ENABLE_MASK_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= wr_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold <= wr_data;
        REG_ENABLE_MASK:    cfg.enable_mask    <= wr_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcsh_update.sv
// Per-channel state and the smoothing and hysteresis update for one reading.
`default_nettype none

module tcsh_update #(
  parameter int CHANNELS     = tcsh_pkg::CHANNELS_DEF,
  parameter int SMOOTH_SHIFT = tcsh_pkg::SMOOTH_SHIFT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  tcsh_pkg::cfg_t                  cfg,
  input  wire logic                       commit,
  input  wire logic [tcsh_pkg::CH_W-1:0]   channel,
  input  wire logic [tcsh_pkg::DATA_W-1:0] reading,
  output tcsh_pkg::res_t                  res
);
  import tcsh_pkg::*;

  localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = DATA_W + SMOOTH_SHIFT + 1;

  // The store needs no reset: the seen flags guard every read of it.
  logic [DATA_W-1:0]   store [CHANNELS];
  logic [CHANNELS-1:0] seen;
  logic [CHANNELS-1:0] flags;
  logic [CHANNELS-1:0] flags_next;
  logic [CHANNELS-1:0] seen_next;

  logic [SEL_W-1:0]  sel;
  logic              in_range;
  logic              enabled;
  logic              upd;
  logic              cur_seen;
  logic              cur_flag;
  logic [DATA_W-1:0] old;
  logic [SUM_W-1:0]  old_x;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] value_new;
  logic              flag_new;
  logic              flag_after;
  logic              valid_after;

  assign sel      = SEL_W'(channel);
  assign in_range = (32'(channel) < CHANNELS);
  assign enabled  = cfg.enable_mask[channel];
  assign cur_seen = in_range && seen[sel];
  assign cur_flag = in_range && flags[sel];
  assign old      = in_range ? store[sel] : '0;
  assign upd      = in_range && enabled;

  // ((2^S - 1) * old + reading) >> S never exceeds 16 bits.
  assign old_x     = SUM_W'(old);
  assign sum       = (old_x << SMOOTH_SHIFT) - old_x + SUM_W'(reading);
  assign value_new = cur_seen ? sum[SMOOTH_SHIFT +: DATA_W] : reading;

  // A touched channel is only tested for release, a released one only for touch.
  assign flag_new = cur_flag ? !(cfg.high_threshold < value_new)
                             : (value_new < cfg.low_threshold);

  assign flag_after  = upd ? flag_new : cur_flag;
  assign valid_after = cur_seen || upd;

  always_comb begin
    flags_next = flags;
    seen_next  = seen;
    if (upd) begin
      flags_next[sel] = flag_new;
      seen_next[sel]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      flags <= '0;
    end else if (commit) begin
      seen  <= seen_next;
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && upd) begin
      store[sel] <= value_new;
    end
  end

  for (genvar c = 0; c < MASK_W; c++) begin : g_mask
    if (c < CHANNELS) begin : g_on
      assign res.touched_mask[c] = flags_next[c];
    end else begin : g_off
      assign res.touched_mask[c] = 1'b0;
    end
  end

  assign res.channel_out    = channel;
  assign res.touched        = flag_after;
  assign res.value_valid    = valid_after;
  assign res.smoothed_value = !valid_after ? '0 : (upd ? value_new : old);

endmodule

`default_nettype wire

>>> rtl/tcsh_out_reg.sv
// Result register on the output channel.
`default_nettype none

module tcsh_out_reg (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  tcsh_pkg::res_t din,
  input  wire logic      out_ready,
  output logic           out_valid,
  output logic           free,
  output tcsh_pkg::res_t dout
);
  import tcsh_pkg::*;

  // The register can take a new result when empty or when its transfer completes now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

>>> rtl/touch_channel_smoother_hysteresis_core.sv
// Top level of the touch channel smoother with hysteresis.
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, channel, raw_reading  in
//   output    out_valid, out_ready, channel_out,        out
//             touched, smoothed_value, value_valid,
//             touched_mask
//   config    wr_en, wr_index, wr_data                  in
//
// One item per cycle while the output accepts; a result passes the input register and then the result register.
// The input register feeds the channel update, whose new state is written at the
// same edge the result register loads, so a following reading sees it at once.
// Reset clears the flags and the valid bits; the smoothed values need no clearing.
// A stalled output holds the result register and then the input register.
`default_nettype none

module touch_channel_smoother_hysteresis_core #(
  parameter int CHANNELS     = tcsh_pkg::CHANNELS_DEF,
  parameter int SMOOTH_SHIFT = tcsh_pkg::SMOOTH_SHIFT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tcsh_pkg::CH_W-1:0]   channel,
  input  wire logic [tcsh_pkg::DATA_W-1:0] raw_reading,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tcsh_pkg::CH_W-1:0]        channel_out,
  output logic                            touched,
  output logic [tcsh_pkg::DATA_W-1:0]      smoothed_value,
  output logic                            value_valid,
  output logic [tcsh_pkg::MASK_W-1:0]      touched_mask,
  input  wire logic                       wr_en,
  input  wire logic [tcsh_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [tcsh_pkg::DATA_W-1:0] wr_data
);
  import tcsh_pkg::*;

  cfg_t cfg;
  res_t res_comb;
  res_t res_q;

  logic              s1_valid;
  logic [CH_W-1:0]   s1_channel;
  logic [DATA_W-1:0] s1_reading;
  logic              res_free;
  logic              advance;

  assign advance  = s1_valid && res_free;
  assign in_ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_channel <= channel;
      s1_reading <= raw_reading;
    end
  end

  tcsh_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tcsh_update #(
    .CHANNELS     (CHANNELS),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) u_update (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .commit  (advance),
    .channel (s1_channel),
    .reading (s1_reading),
    .res     (res_comb)
  );

  tcsh_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .din       (res_comb),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (res_free),
    .dout      (res_q)
  );

  assign channel_out    = res_q.channel_out;
  assign touched        = res_q.touched;
  assign smoothed_value = res_q.smoothed_value;
  assign value_valid    = res_q.value_valid;
  assign touched_mask   = res_q.touched_mask;

endmodule

`default_nettype wire

>>> tb/touch_channel_smoother_hysteresis_core_tb.sv
// Self-checking testbench for the touch channel smoother with hysteresis.
`timescale 1ns / 1ps

module touch_channel_smoother_hysteresis_core_tb;
  import tcsh_pkg::*;

  localparam int NCH = CHANNELS_DEF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CH_W-1:0]     channel = '0;
  logic [DATA_W-1:0]   raw_reading = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CH_W-1:0]     channel_out;
  logic                touched;
  logic [DATA_W-1:0]   smoothed_value;
  logic                value_valid;
  logic [MASK_W-1:0]   touched_mask;
  logic                wr_en = 1'b0;
  logic [IDX_W-1:0]    wr_index = '0;
  logic [DATA_W-1:0]   wr_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  // Predicted state of every channel, kept in transfer order.
  cfg_t              cfg_model;
  logic [DATA_W-1:0] level_store [NCH];
  logic [NCH-1:0]    seen_bits;
  logic [NCH-1:0]    touch_bits;
  res_t              readings_due [$];

  touch_channel_smoother_hysteresis_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .channel(channel), .raw_reading(raw_reading),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel_out(channel_out), .touched(touched), .smoothed_value(smoothed_value),
    .value_valid(value_valid), .touched_mask(touched_mask),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t predict_reading(input logic [CH_W-1:0] ch,
                                           input logic [DATA_W-1:0] raw);
    res_t                        r;
    logic [DATA_W+SMOOTH_SHIFT_DEF:0] acc;
    if (cfg_model.enable_mask[ch]) begin
      if (!seen_bits[ch]) begin
        level_store[ch] = raw;
        seen_bits[ch] = 1'b1;
      end else begin
        acc = ({{(SMOOTH_SHIFT_DEF+1){1'b0}}, level_store[ch]} << SMOOTH_SHIFT_DEF)
              - level_store[ch] + raw;
        level_store[ch] = DATA_W'(acc >> SMOOTH_SHIFT_DEF);
      end
      // A touched channel may only release and a released one may only touch.
      if (touch_bits[ch]) begin
        if (level_store[ch] > cfg_model.high_threshold) touch_bits[ch] = 1'b0;
      end else if (level_store[ch] < cfg_model.low_threshold) begin
        touch_bits[ch] = 1'b1;
      end
    end
    r.channel_out    = ch;
    r.touched        = touch_bits[ch];
    r.value_valid    = seen_bits[ch];
    r.smoothed_value = seen_bits[ch] ? level_store[ch] : '0;
    r.touched_mask   = touch_bits;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want, input logic [CH_W-1:0] ch);
    if (got !== want)
      report_mismatch($sformatf("channel %0d %s got %0h expected %0h", ch, name, got, want));
  endtask

  // Result side: random back-pressure and comparison against the oldest prediction.
  always @(posedge clk) begin
    res_t due;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("result for channel %0d with nothing expected", channel_out));
      end else begin
        due = readings_due.pop_front();
        check_field("channel_out", DATA_W'(channel_out), DATA_W'(due.channel_out),
                    due.channel_out);
        check_field("touched", DATA_W'(touched), DATA_W'(due.touched), due.channel_out);
        check_field("smoothed_value", smoothed_value, due.smoothed_value, due.channel_out);
        check_field("value_valid", DATA_W'(value_valid), DATA_W'(due.value_valid),
                    due.channel_out);
        check_field("touched_mask", DATA_W'(touched_mask), DATA_W'(due.touched_mask),
                    due.channel_out);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_reading(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    channel     <= ch;
    raw_reading <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    readings_due.push_back(predict_reading(ch, raw));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                            input logic [MASK_W-1:0] mask);
    wait_for_idle();
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_ENABLE_MASK, {{(DATA_W-MASK_W){1'b0}}, mask});
    cfg_model.low_threshold  = lo;
    cfg_model.high_threshold = hi;
    cfg_model.enable_mask    = mask;
  endtask

  // Default thresholds never touch; first readings load directly.
  task automatic test_first_readings();
    send_reading(3'd0, 16'h0000);
    send_reading(3'd1, 16'hFFFF);
    send_reading(3'd2, 16'h8000);
    send_reading(3'd3, 16'h7FFF);
    send_reading(3'd4, 16'h5555);
    send_reading(3'd5, 16'hAAAA);
    send_reading(3'd6, 16'h0001);
    send_reading(3'd7, 16'hFFFE);
    send_reading(3'd1, 16'h0000);
    send_reading(3'd0, 16'hFFFF);
  endtask

  task automatic test_touch_and_release();
    set_config(16'h2000, 16'h3000, 8'hFF);
    send_reading(3'd0, 16'h1FFF);
    send_reading(3'd0, 16'hFFFF);
    send_reading(3'd6, 16'h0000);
    send_reading(3'd4, 16'h2000);
    send_reading(3'd6, 16'h2FFF);
  endtask

  // Low above high: the flag still changes at most once per reading.
  task automatic test_crossed_thresholds();
    set_config(16'hFFFF, 16'h0000, 8'hFF);
    send_reading(3'd1, 16'hFFFF);
    send_reading(3'd1, 16'hFFFF);
    send_reading(3'd6, 16'h0000);
    send_reading(3'd7, 16'hFFFF);
  endtask

  task automatic test_disabled_channels();
    set_config(16'h8000, 16'h9000, 8'h0F);
    send_reading(3'd5, 16'h0000);
    send_reading(3'd7, 16'h1234);
    send_reading(3'd0, 16'h0000);
    set_config(16'h8000, 16'h9000, 8'h00);
    send_reading(3'd3, 16'h0000);
    send_reading(3'd6, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int per_setting);
    logic [NCH-1:0]    level_high;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] raw;
    int                pick;
    level_high = '0;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 37; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        case (setting)
          0: set_config(16'h4000, 16'h6000, 8'hFF);
          1: begin
            raw = 16'($urandom);
            set_config(raw, raw + 16'($urandom_range(16'hFFFF - raw, 0)),
                       8'($urandom));
          end
          2: set_config(16'hFFFF, 16'h0000, 8'hFF);
          default: set_config(16'h0000, 16'hFFFF, 8'($urandom));
        endcase
        repeat (per_setting) begin
          // Disabled channels that never took a reading are left alone.
          do ch = CH_W'($urandom_range(NCH - 1));
          while (!(cfg_model.enable_mask[ch] || seen_bits[ch]));
          pick = $urandom_range(99);
          if (pick < 10)
            raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else if (pick < 30)
            raw = 16'($urandom);
          else if (level_high[ch])
            raw = 16'($urandom_range(16'hFFFF, cfg_model.high_threshold));
          else
            raw = 16'($urandom_range(cfg_model.low_threshold, 0));
          // Each channel dwells near one level so the slow average can cross over.
          if ($urandom_range(99) < 8) level_high[ch] = ~level_high[ch];
          send_reading(ch, raw);
        end
      end
    end
  endtask

  initial begin
    cfg_model.low_threshold  = LOW_THRESHOLD_RST;
    cfg_model.high_threshold = HIGH_THRESHOLD_RST;
    cfg_model.enable_mask    = ENABLE_MASK_RST;
    seen_bits  = '0;
    touch_bits = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 52;
    test_first_readings();
    test_touch_and_release();
    test_crossed_thresholds();
    test_disabled_channels();
    test_random_traffic(70);
    wait_for_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", readings_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
